[rtl/core/sfdc_pkg.sv]
package sfdc_pkg;

    localparam int unsigned PosW = 5;
    localparam int unsigned SumW = 13;
    localparam int unsigned IdW = 11;
    localparam int unsigned PayloadW = 64;
    localparam int unsigned LaneCnt = 8;

    localparam logic [7:0] START_BYTE = 8'hF0;
    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] CHAN_A = 8'hAA;
    localparam logic [7:0] CHAN_B = 8'hBB;

    localparam logic [PosW-1:0] POS_HUNT = 5'd0;
    localparam logic [PosW-1:0] POS_SYNC = 5'd1;
    localparam logic [PosW-1:0] POS_CHAN = 5'd2;
    localparam logic [PosW-1:0] POS_ID_HIGH = 5'd4;
    localparam logic [PosW-1:0] POS_ID_LOW = 5'd5;
    localparam logic [PosW-1:0] POS_PAYLOAD = 5'd9;
    localparam logic [PosW-1:0] POS_LAST = 5'd17;

    typedef struct packed {
        logic [7:0]          frame_channel;
        logic [IdW-1:0]      message_id;
        logic [PayloadW-1:0] payload;
        logic                checksum_ok;
    } t_result;

    function automatic logic [7:0] fold_checksum(input logic [SumW-1:0] sum);
        logic [8:0] s1;
        logic [8:0] s2;
        s1 = {1'b0, sum[7:0]} + {4'b0, sum[SumW-1:8]};
        s2 = {1'b0, s1[7:0]} + {8'b0, s1[8]};
        return 8'(9'd0 - s2);
    endfunction

endpackage

[rtl/core/sfdc_in_reg.sv]
module sfdc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[rtl/core/sfdc_deframer.sv]
module sfdc_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [7:0]                      i_byte,
    output logic                            o_res_valid,
    output sfdc_pkg::t_result               o_res,
    output logic [sfdc_pkg::PosW-1:0]       o_pos
);

    logic [sfdc_pkg::PosW-1:0]     r_pos;
    logic [sfdc_pkg::SumW-1:0]     r_sum;
    logic [7:0]                    r_channel;
    logic [7:0]                    r_id_high;
    logic [2:0]                    r_id_low;
    logic [sfdc_pkg::PayloadW-1:0] r_payload;

    logic [sfdc_pkg::PosW-1:0]     n_pos;
    logic [sfdc_pkg::SumW-1:0]     n_sum;
    logic [7:0]                    n_channel;
    logic [7:0]                    n_id_high;
    logic [2:0]                    n_id_low;
    logic [sfdc_pkg::PayloadW-1:0] n_payload;

    logic                          is_start;
    logic [sfdc_pkg::PosW-1:0]     hunt_pos;
    logic [sfdc_pkg::SumW-1:0]     hunt_sum;
    logic [sfdc_pkg::SumW-1:0]     add_sum;
    logic [sfdc_pkg::PosW-1:0]     lane_off;

    assign is_start = (i_byte == sfdc_pkg::START_BYTE);
    assign hunt_pos = is_start ? sfdc_pkg::POS_SYNC : sfdc_pkg::POS_HUNT;
    assign hunt_sum = is_start ? sfdc_pkg::SumW'(i_byte) : '0;
    assign add_sum  = r_sum + sfdc_pkg::SumW'(i_byte);
    assign lane_off = r_pos - sfdc_pkg::POS_PAYLOAD;

    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_channel = r_channel;
        n_id_high = r_id_high;
        n_id_low  = r_id_low;
        n_payload = r_payload;
        priority if (r_pos == sfdc_pkg::POS_HUNT || r_pos > sfdc_pkg::POS_LAST) begin
            n_pos = hunt_pos;
            n_sum = hunt_sum;
        end else if (r_pos == sfdc_pkg::POS_SYNC) begin
            if (i_byte == sfdc_pkg::SYNC_BYTE) begin
                n_pos = sfdc_pkg::POS_CHAN;
                n_sum = add_sum;
            end else begin
                n_pos = hunt_pos;
                n_sum = hunt_sum;
            end
        end else if (r_pos == sfdc_pkg::POS_CHAN) begin
            if (i_byte == sfdc_pkg::CHAN_A || i_byte == sfdc_pkg::CHAN_B) begin
                n_channel = i_byte;
                n_pos     = r_pos + 1'b1;
                n_sum     = add_sum;
            end else begin
                n_pos = hunt_pos;
                n_sum = hunt_sum;
            end
        end else if (r_pos == sfdc_pkg::POS_LAST) begin
            n_pos = sfdc_pkg::POS_HUNT;
            n_sum = '0;
        end else begin
            if (r_pos == sfdc_pkg::POS_ID_HIGH) begin
                n_id_high = i_byte;
            end else if (r_pos == sfdc_pkg::POS_ID_LOW) begin
                n_id_low = i_byte[7:5];
            end else if (r_pos >= sfdc_pkg::POS_PAYLOAD) begin
                for (int i = 0; i < sfdc_pkg::LaneCnt; i++) begin
                    if (lane_off[2:0] == 3'(i)) begin
                        n_payload[i*8 +: 8] = i_byte;
                    end
                end
            end
            n_pos = r_pos + 1'b1;
            n_sum = add_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= sfdc_pkg::POS_HUNT;
            r_sum     <= '0;
            r_channel <= '0;
            r_id_high <= '0;
            r_id_low  <= '0;
            r_payload <= '0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_channel <= n_channel;
            r_id_high <= n_id_high;
            r_id_low  <= n_id_low;
            r_payload <= n_payload;
        end
    end

    assign o_res_valid       = (r_pos == sfdc_pkg::POS_LAST);
    assign o_res.frame_channel = r_channel;
    assign o_res.message_id  = {r_id_high, r_id_low};
    assign o_res.payload     = r_payload;
    assign o_res.checksum_ok = (i_byte == sfdc_pkg::fold_checksum(r_sum));
    assign o_pos             = r_pos;

endmodule

[rtl/core/sfdc_out_reg.sv]
module sfdc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfdc_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output sfdc_pkg::t_result o_res
);

    logic              r_valid;
    sfdc_pkg::t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/core/sync_frame_deframer_checksum.sv]
// Byte-stream deframer: hunts for 18-byte frames starting F0 55 (AA|BB) and
// emits one item per complete frame with channel, 11-bit message id, the eight
// payload bytes (byte 9 lowest) and a checksum flag; a bad checksum still
// yields an item with checksum_ok low. One byte is taken every cycle unless the
// input side stalls: a byte is held in the input register, is decoded against
// the frame position and running sum, and when byte 17 is decoded the finished
// frame is loaded into the output register.
// The input side stalls only while a finished frame waits on a stalled output.
module sync_frame_deframer_checksum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_stall,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [7:0]                        o_frame_channel,
    output logic [sfdc_pkg::IdW-1:0]          o_message_id,
    output logic [sfdc_pkg::PayloadW-1:0]     o_payload,
    output logic                              o_checksum_ok
);

    logic                      in_valid;
    logic [7:0]                in_byte;
    logic                      fire;
    logic                      res_valid;
    logic                      load;
    logic                      out_free;
    logic [sfdc_pkg::PosW-1:0] pos;
    sfdc_pkg::t_result         res;
    sfdc_pkg::t_result         out_res;

    assign fire = in_valid && (!res_valid || out_free);
    assign load = fire && res_valid;

    sfdc_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_take    (fire),
        .o_stall   (o_stall),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    sfdc_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_pos       (pos)
    );

    sfdc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_frame_channel = out_res.frame_channel;
    assign o_message_id    = out_res.message_id;
    assign o_payload       = out_res.payload;
    assign o_checksum_ok   = out_res.checksum_ok;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos <= sfdc_pkg::POS_LAST)
        else $error("frame position out of range");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!o_valid || !i_stall))
        else $error("result loaded over a waiting item");

    a_held_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !fire) |=> (in_valid && $stable(in_byte)))
        else $error("held input byte lost");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_valid && pos == sfdc_pkg::POS_HUNT))
        else $error("frame end did not return to hunting");

endmodule
